### src/lcd_decimal_number_writer_top_assert.svh
// Assertion macros shared by the decimal writer modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LCD_DECIMAL_NUMBER_WRITER_TOP_ASSERT_SVH
`define LCD_DECIMAL_NUMBER_WRITER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LDW_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decimal writer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LDW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decimal writer assertion failed");

`endif

### src/ldw_pkg.sv
// Package for the LCD decimal number writer: payload structs, codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ldw_pkg;

  // Number of valid display columns.
  localparam int COLUMNS = 16;

  // Cursor command bases and character codes.
  localparam logic [7:0] CMD_ROW1    = 8'h80;
  localparam logic [7:0] CMD_ROW2    = 8'hC0;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  // Reciprocal of ten for 16-bit values: q = (n * RECIP10) >> RECIP_SHIFT.
  localparam logic [31:0] RECIP10     = 32'h0000_CCCD;
  localparam int          RECIP_SHIFT = 19;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_ROW = 2'd1;
  localparam logic [1:0] STATUS_BAD_COL = 2'd2;

  typedef struct packed {
    logic signed [15:0] number;
    logic [1:0]         row;
    logic [4:0]         col;
  } in_payload_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       reg_select;
    logic       last;
    logic [1:0] status;
  } out_payload_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_ERR,
    ST_CMD,
    ST_MINUS,
    ST_DIG
  } fsm_state_t;

  // Source of the byte being sent out.
  typedef enum logic [1:0] {
    SRC_ERR,
    SRC_CMD,
    SRC_MINUS,
    SRC_DIG
  } src_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic push;
    src_t src;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad_pos;
    logic neg;
    logic conv_last;
    logic half;
    logic dig_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### src/ldw_datapath.sv
// Datapath of the LCD decimal writer: input capture, divide-by-ten digit
// extraction, digit buffer and output register. Depends on ldw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldw_datapath (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ldw_pkg::in_payload_t in_payload,
  input  wire                  out_ready,
  input  ldw_pkg::ctrl_cmd_t   cmd,
  output ldw_pkg::dp_stat_t    stat,
  output logic                 out_valid,
  output ldw_pkg::out_payload_t out_payload
);
  import ldw_pkg::*;

  `include "lcd_decimal_number_writer_top_assert.svh"

  logic [15:0]  mag_r, mag_nxt;
  logic         neg_r, neg_nxt;
  logic [7:0]   cmd_r, cmd_nxt;
  logic [1:0]   status_r, status_nxt;
  logic [2:0]   dsel_r, dsel_nxt;
  logic         half_r, half_nxt;
  logic [3:0]   digits_r [5];
  logic         out_valid_r, out_valid_nxt;
  out_payload_t out_r, out_nxt;

  logic [15:0]  load_mag;
  logic [7:0]   base;
  logic [31:0]  prod;
  logic [15:0]  quot;
  logic [15:0]  rem16;
  logic [7:0]   emit_byte;
  logic         out_free;

  // Position check and cursor command for the incoming transaction.
  always_comb begin
    status_nxt = STATUS_OK;
    base       = CMD_ROW1;
    if (in_payload.col == 5'd0 || 32'(in_payload.col) > COLUMNS) begin
      status_nxt = STATUS_BAD_COL;
    end else if (in_payload.row == 2'd1) begin
      base = CMD_ROW1;
    end else if (in_payload.row == 2'd2) begin
      base = CMD_ROW2;
    end else begin
      status_nxt = STATUS_BAD_ROW;
    end
  end

  // Magnitude of the number; the most negative value maps to 32768.
  assign load_mag = in_payload.number[15] ? (~unsigned'(in_payload.number) + 16'd1)
                                          : unsigned'(in_payload.number);

  // One decimal digit per step via multiplication by the reciprocal of ten.
  assign prod  = {16'd0, mag_r} * RECIP10;
  assign quot  = 16'(prod[31:RECIP_SHIFT]);
  assign rem16 = mag_r - ((quot << 3) + (quot << 1));

  // Working registers.
  always_comb begin
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    cmd_nxt  = cmd_r;
    dsel_nxt = dsel_r;
    half_nxt = half_r;
    if (cmd.load) begin
      mag_nxt  = load_mag;
      neg_nxt  = in_payload.number[15];
      cmd_nxt  = base + {3'd0, in_payload.col} - 8'd1;
      dsel_nxt = 3'd0;
      half_nxt = 1'b0;
    end else if (cmd.conv_step) begin
      mag_nxt = quot;
      if (quot != 16'd0) begin
        dsel_nxt = dsel_r + 3'd1;
      end
    end else if (cmd.push && cmd.src != SRC_ERR) begin
      half_nxt = ~half_r;
      if (cmd.src == SRC_DIG && half_r && dsel_r != 3'd0) begin
        dsel_nxt = dsel_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsel_r <= 3'd0;
      half_r <= 1'b0;
    end else begin
      dsel_r <= dsel_nxt;
      half_r <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    cmd_r <= cmd_nxt;
    if (cmd.load) begin
      status_r <= status_nxt;
    end
  end

  // Digit buffer, least significant digit at index zero.
  always_ff @(posedge clk) begin
    if (cmd.conv_step) begin
      digits_r[dsel_r] <= rem16[3:0];
    end
  end

  // Byte selected for output.
  always_comb begin
    case (cmd.src)
      SRC_CMD:   emit_byte = cmd_r;
      SRC_MINUS: emit_byte = ASCII_MINUS;
      SRC_DIG:   emit_byte = {ASCII_DIGIT_HI, digits_r[dsel_r]};
      default:   emit_byte = 8'd0;
    endcase
  end

  // Output register, refilled whenever it is empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
      if (cmd.src == SRC_ERR) begin
        out_nxt.nibble     = 4'd0;
        out_nxt.reg_select = 1'b0;
        out_nxt.last       = 1'b1;
        out_nxt.status     = status_r;
      end else begin
        out_nxt.nibble     = half_r ? emit_byte[3:0] : emit_byte[7:4];
        out_nxt.reg_select = (cmd.src != SRC_CMD);
        out_nxt.last       = (cmd.src == SRC_DIG) && half_r && (dsel_r == 3'd0);
        out_nxt.status     = STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  // Status toward the controller.
  assign stat.bad_pos   = (status_nxt != STATUS_OK);
  assign stat.neg       = neg_r;
  assign stat.conv_last = (quot == 16'd0);
  assign stat.half      = half_r;
  assign stat.dig_last  = (dsel_r == 3'd0);
  assign stat.out_free  = out_free;

  // A 16-bit magnitude never needs more than five digits.
  `LDW_ASSERT_SAME(a_five_digits, cmd.conv_step && dsel_r == 3'd4, quot == 16'd0)
  // The controller only pushes into a free output register.
  `LDW_ASSERT_SAME(a_push_free, cmd.push, out_free)

endmodule

`default_nettype wire

### src/ldw_ctrl.sv
// Controller state machine of the LCD decimal writer: sequences digit
// extraction and the nibble transfers. Depends on ldw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldw_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  ldw_pkg::dp_stat_t  stat,
  output ldw_pkg::ctrl_cmd_t cmd
);
  import ldw_pkg::*;

  `include "lcd_decimal_number_writer_top_assert.svh"

  fsm_state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.bad_pos ? ST_ERR : ST_CONV;
        end
      end
      ST_CONV: begin
        if (stat.conv_last) begin
          state_nxt = ST_CMD;
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CMD: begin
        if (stat.out_free && stat.half) begin
          state_nxt = stat.neg ? ST_MINUS : ST_DIG;
        end
      end
      ST_MINUS: begin
        if (stat.out_free && stat.half) begin
          state_nxt = ST_DIG;
        end
      end
      ST_DIG: begin
        if (stat.out_free && stat.half && stat.dig_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs toward the datapath.
  always_comb begin
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.conv_step = 1'b0;
    cmd.push      = 1'b0;
    cmd.src       = SRC_ERR;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV: cmd.conv_step = 1'b1;
      ST_ERR: begin
        cmd.push = stat.out_free;
        cmd.src  = SRC_ERR;
      end
      ST_CMD: begin
        cmd.push = stat.out_free;
        cmd.src  = SRC_CMD;
      end
      ST_MINUS: begin
        cmd.push = stat.out_free;
        cmd.src  = SRC_MINUS;
      end
      ST_DIG: begin
        cmd.push = stat.out_free;
        cmd.src  = SRC_DIG;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // An accepted transaction always leaves the idle state.
  `LDW_ASSERT_NEXT(a_load_busy, cmd.load, state_r != ST_IDLE)
  // The final digit nibble returns the controller to idle.
  `LDW_ASSERT_NEXT(a_last_idle,
                   state_r == ST_DIG && cmd.push && stat.half && stat.dig_last,
                   state_r == ST_IDLE)

endmodule

`default_nettype wire

### src/lcd_decimal_number_writer_top.sv
// Top level of the LCD decimal number writer for a 4-bit character display bus.
// Instantiates ldw_ctrl and ldw_datapath; depends on ldw_pkg.
//
// Usage: the input channel (in_valid/in_ready/in_payload) takes a signed 16-bit
// number with a row and column. Each transaction produces a run of results on
// the output channel (out_valid/out_ready/out_payload), one per 4-bit transfer:
// the cursor command, an optional '-', then the decimal digits, each byte high
// nibble first. The final result of a run has last set. A bad column or row
// gives a single result carrying the error status.
// A number has 1 to 5 decimal digits. They come from a single divide-by-ten
// unit, one digit per cycle, and the nibbles leave one per cycle through the
// output register while the receiver is ready. One item is handled at a
// time; in_ready is high only between items, and the next item is taken while
// the last result still waits.
// Reset clears the controller and empties the output register. When the
// receiver stalls, the current result holds and the sequence pauses.
`timescale 1ns / 1ps
`default_nettype none

module lcd_decimal_number_writer_top (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  ldw_pkg::in_payload_t  in_payload,
  output logic                  out_valid,
  input  wire                   out_ready,
  output ldw_pkg::out_payload_t out_payload
);
  import ldw_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer.
  ldw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Conversion and output datapath.
  ldw_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire
